[rtl/core/pidc_pkg.sv]
// ----------------------------------------------------------------------------
// pidc_pkg
// Types and fixed constants shared by the PID controller step block.
// ----------------------------------------------------------------------------
`default_nettype none

package pidc_pkg;

    // Output scaling: the term sum is divided by SCALE, truncating toward zero
    localparam int unsigned SCALE       = 128;
    localparam int unsigned SCALE_SHIFT = $clog2(SCALE);

    localparam logic signed [15:0] DRIVE_LIMIT    = 16'sd32767;
    localparam logic signed [31:0] DRIVE_LIMIT_W  = 32'sd32767;
    localparam logic signed [31:0] INTEGRAL_LIMIT = 32'sd1073741823;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ERROR_BOUND    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEGRAL_BOUND = 3'd4;

    localparam logic [14:0] RST_PROP_GAIN      = 15'd128;
    localparam logic [14:0] RST_INTEG_GAIN     = 15'd0;
    localparam logic [14:0] RST_DERIV_GAIN     = 15'd0;
    localparam logic [14:0] RST_ERROR_BOUND    = 15'd254;
    localparam logic [29:0] RST_INTEGRAL_BOUND = 30'd1073741823;

    // Integrator clamp outcome
    typedef enum logic [1:0] {
        ISAT_NONE = 2'd0,
        ISAT_POS  = 2'd1,
        ISAT_NEG  = 2'd2
    } t_isat;

    // Front stage result: P and D terms, updated accumulator, clamp outcome
    typedef struct packed {
        logic signed [15:0] p_term;
        logic signed [15:0] d_term;
        logic signed [31:0] error_sum;
        t_isat              isat;
    } t_front;

    // Integral stage result: all three terms
    typedef struct packed {
        logic signed [15:0] p_term;
        logic signed [31:0] i_term;
        logic signed [15:0] d_term;
    } t_terms;

endpackage

`default_nettype wire

[rtl/core/pidc_front.sv]
// ----------------------------------------------------------------------------
// pidc_front
// Error, P and D terms, and the clamped integrator state update.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_front (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic                  i_drain,
    input  wire logic                  i_cmd,
    input  wire logic signed [15:0]    i_set_point,
    input  wire logic signed [15:0]    i_measurement,
    input  wire logic [14:0]           i_prop_gain,
    input  wire logic [14:0]           i_deriv_gain,
    input  wire logic [14:0]           i_error_bound,
    input  wire logic [29:0]           i_integral_bound,
    output logic                       o_valid,
    output pidc_pkg::t_front           o_front
);

    logic signed [31:0] r_error_sum;
    logic signed [15:0] r_prev_meas;
    logic               r_valid;
    pidc_pkg::t_front   r_front;

    logic signed [15:0] err;
    logic signed [16:0] err_x;
    logic signed [16:0] eb_pos;
    logic signed [16:0] eb_neg;
    logic signed [31:0] p_prod;
    logic signed [15:0] d_diff;
    logic signed [31:0] d_prod;
    logic signed [32:0] acc_sum;
    logic signed [32:0] ib_pos;
    logic signed [32:0] ib_neg;
    pidc_pkg::t_front   n_front;
    logic signed [31:0] n_error_sum;

    always_comb begin
        err    = i_set_point - i_measurement;
        err_x  = $signed({err[15], err});
        eb_pos = $signed({2'b00, i_error_bound});
        eb_neg = -eb_pos;
        p_prod = $signed({1'b0, i_prop_gain}) * err;

        d_diff = r_prev_meas - i_measurement;
        d_prod = $signed({1'b0, i_deriv_gain}) * d_diff;

        acc_sum = $signed({r_error_sum[31], r_error_sum}) + $signed({{17{err[15]}}, err});
        ib_pos  = $signed({3'b000, i_integral_bound});
        ib_neg  = -ib_pos;

        if (err_x > eb_pos) begin
            n_front.p_term = pidc_pkg::DRIVE_LIMIT;
        end else if (err_x < eb_neg) begin
            n_front.p_term = -pidc_pkg::DRIVE_LIMIT;
        end else begin
            n_front.p_term = p_prod[15:0];
        end

        if (acc_sum > ib_pos) begin
            n_error_sum  = ib_pos[31:0];
            n_front.isat = pidc_pkg::ISAT_POS;
        end else if (acc_sum < ib_neg) begin
            n_error_sum  = ib_neg[31:0];
            n_front.isat = pidc_pkg::ISAT_NEG;
        end else begin
            n_error_sum  = acc_sum[31:0];
            n_front.isat = pidc_pkg::ISAT_NONE;
        end

        n_front.d_term    = d_prod[15:0];
        n_front.error_sum = n_error_sum;
    end

    // State moves once per request, as it leaves the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_error_sum <= '0;
            r_prev_meas <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (i_step) begin
                if (i_cmd) begin
                    r_error_sum <= '0;
                end else begin
                    r_error_sum <= n_error_sum;
                    r_prev_meas <= i_measurement;
                end
            end
            if (i_step && !i_cmd) begin
                r_valid <= 1'b1;
            end else if (i_drain) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && !i_cmd) begin
            r_front <= n_front;
        end
    end

    assign o_valid = r_valid;
    assign o_front = r_front;

endmodule

`default_nettype wire

[rtl/core/pidc_integ.sv]
// ----------------------------------------------------------------------------
// pidc_integ
// Integral term: gain times accumulator, or the limit when clamped.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_integ (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire logic              i_drain,
    input  wire pidc_pkg::t_front  i_front,
    input  wire logic [14:0]       i_integ_gain,
    output logic                   o_valid,
    output pidc_pkg::t_terms       o_terms
);

    logic               r_valid;
    pidc_pkg::t_terms   r_terms;
    logic signed [47:0] i_prod;
    pidc_pkg::t_terms   n_terms;

    always_comb begin
        i_prod = $signed({1'b0, i_integ_gain}) * i_front.error_sum;
        n_terms.p_term = i_front.p_term;
        n_terms.d_term = i_front.d_term;
        case (i_front.isat)
            pidc_pkg::ISAT_POS: n_terms.i_term = pidc_pkg::INTEGRAL_LIMIT;
            pidc_pkg::ISAT_NEG: n_terms.i_term = -pidc_pkg::INTEGRAL_LIMIT;
            default:            n_terms.i_term = i_prod[31:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_terms <= n_terms;
        end
    end

    assign o_valid = r_valid;
    assign o_terms = r_terms;

endmodule

`default_nettype wire

[rtl/core/pidc_out.sv]
// ----------------------------------------------------------------------------
// pidc_out
// Term sum, scaling toward zero, drive clamp and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_out (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire logic              i_drain,
    input  wire pidc_pkg::t_terms  i_terms,
    output logic                   o_valid,
    output logic signed [15:0]     o_drive
);

    localparam logic signed [31:0] BIAS = 32'(pidc_pkg::SCALE - 1);

    logic               r_valid;
    logic signed [15:0] r_drive;
    logic signed [31:0] sum;
    logic signed [31:0] quo;
    logic signed [15:0] n_drive;

    always_comb begin
        sum = $signed({{16{i_terms.p_term[15]}}, i_terms.p_term}) + i_terms.i_term
            + $signed({{16{i_terms.d_term[15]}}, i_terms.d_term});
        // bias negatives so the shift truncates toward zero
        quo = (sum + (sum[31] ? BIAS : 32'sd0)) >>> pidc_pkg::SCALE_SHIFT;
        if (quo > pidc_pkg::DRIVE_LIMIT_W) begin
            n_drive = pidc_pkg::DRIVE_LIMIT;
        end else if (quo < -pidc_pkg::DRIVE_LIMIT_W) begin
            n_drive = -pidc_pkg::DRIVE_LIMIT;
        end else begin
            n_drive = quo[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_drain) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_drive <= n_drive;
        end
    end

    assign o_valid = r_valid;
    assign o_drive = r_drive;

endmodule

`default_nettype wire

[rtl/core/pid_controller_step.sv]
// ----------------------------------------------------------------------------
// pid_controller_step
// Discrete PID controller step with anti-windup, fully pipelined.
// ----------------------------------------------------------------------------
// One request is taken per clock while o_stall is low. A compute request
// passes through the input register, error/P/D/integrator stage, integral
// multiply stage, then the sum, scale and clamp into the result register.
// The integrator update is the loop that lets the next request follow
// directly. A clear request zeroes the integrator as it leaves the input
// register and produces no result. Stall on the result side back-pressures
// the whole pipe; configuration is taken on any cycle.
`default_nettype none

module pid_controller_step (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic                                i_cmd,
    input  wire logic signed [15:0]                  i_set_point,
    input  wire logic signed [15:0]                  i_measurement,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic signed [15:0]                       o_drive,
    input  wire logic                                i_cfg_valid,
    output logic                                     o_cfg_ready,
    input  wire logic [pidc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [29:0]                         i_cfg_data
);

    logic [14:0] r_prop_gain;
    logic [14:0] r_integ_gain;
    logic [14:0] r_deriv_gain;
    logic [14:0] r_error_bound;
    logic [29:0] r_integral_bound;

    logic               r_in_valid;
    logic               r_in_cmd;
    logic signed [15:0] r_in_sp;
    logic signed [15:0] r_in_mv;

    logic             front_valid;
    pidc_pkg::t_front front_data;
    logic             integ_valid;
    pidc_pkg::t_terms integ_data;
    logic             out_valid;

    logic out_free;
    logic integ_free;
    logic front_free;
    logic adv_in;
    logic adv_front;
    logic adv_integ;
    logic accept;

    // Pipe advance, from the result end back
    always_comb begin
        out_free   = !out_valid || !i_stall;
        adv_integ  = integ_valid && out_free;
        integ_free = !integ_valid || out_free;
        adv_front  = front_valid && integ_free;
        front_free = !front_valid || integ_free;
        adv_in     = r_in_valid && (r_in_cmd || front_free);
        o_stall    = r_in_valid && !adv_in;
        accept     = i_valid && !o_stall;
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain      <= pidc_pkg::RST_PROP_GAIN;
            r_integ_gain     <= pidc_pkg::RST_INTEG_GAIN;
            r_deriv_gain     <= pidc_pkg::RST_DERIV_GAIN;
            r_error_bound    <= pidc_pkg::RST_ERROR_BOUND;
            r_integral_bound <= pidc_pkg::RST_INTEGRAL_BOUND;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pidc_pkg::CFG_PROP_GAIN:      r_prop_gain      <= i_cfg_data[14:0];
                pidc_pkg::CFG_INTEG_GAIN:     r_integ_gain     <= i_cfg_data[14:0];
                pidc_pkg::CFG_DERIV_GAIN:     r_deriv_gain     <= i_cfg_data[14:0];
                pidc_pkg::CFG_ERROR_BOUND:    r_error_bound    <= i_cfg_data[14:0];
                pidc_pkg::CFG_INTEGRAL_BOUND: r_integral_bound <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (adv_in) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_cmd <= i_cmd;
            r_in_sp  <= i_set_point;
            r_in_mv  <= i_measurement;
        end
    end

    pidc_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_step           (adv_in),
        .i_drain          (adv_front),
        .i_cmd            (r_in_cmd),
        .i_set_point      (r_in_sp),
        .i_measurement    (r_in_mv),
        .i_prop_gain      (r_prop_gain),
        .i_deriv_gain     (r_deriv_gain),
        .i_error_bound    (r_error_bound),
        .i_integral_bound (r_integral_bound),
        .o_valid          (front_valid),
        .o_front          (front_data)
    );

    pidc_integ u_integ (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (adv_front),
        .i_drain      (adv_integ),
        .i_front      (front_data),
        .i_integ_gain (r_integ_gain),
        .o_valid      (integ_valid),
        .o_terms      (integ_data)
    );

    pidc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv_integ),
        .i_drain (out_valid && !i_stall),
        .i_terms (integ_data),
        .o_valid (out_valid),
        .o_drive (o_drive)
    );

    assign o_valid = out_valid;

endmodule

`default_nettype wire

[rtl/core/pidc_checker.sv]
// ----------------------------------------------------------------------------
// pidc_checker
// Port-level checks for the PID controller step block.
// ----------------------------------------------------------------------------
`default_nettype none

module pidc_checker (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    input  wire logic                                o_stall,
    input  wire logic                                i_cmd,
    input  wire logic signed [15:0]                  i_set_point,
    input  wire logic signed [15:0]                  i_measurement,
    input  wire logic                                o_valid,
    input  wire logic                                i_stall,
    input  wire logic signed [15:0]                  o_drive,
    input  wire logic                                i_cfg_valid,
    input  wire logic                                o_cfg_ready,
    input  wire logic [pidc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [29:0]                         i_cfg_data
);

    // Held result must not move while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_drive))
        else $error("result changed under stall");

    // Drive is clamped symmetrically, never the most negative code
    a_drive_sym: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_drive != 16'sh8000)
        else $error("drive outside symmetric limit");

    // Input side only stalls when the pipe is full behind a stalled result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output back-pressure");

    // Reset empties the pipe
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("pipe not empty after reset");

endmodule

bind pid_controller_step pidc_checker u_pidc_checker (.*);

`default_nettype wire

[tb/tb_pid_controller_step.sv]
// ----------------------------------------------------------------------------
// tb_pid_controller_step
// Self-checking bench for the PID controller step block. A queue-fed driver
// offers control requests with random gaps. The receiver stalls at random,
// including one long hold-off that backs up the pipe. A behavioural PID
// model predicts each drive value, and the monitor compares the results in
// order. Gains and bounds are reprogrammed between phases while the pipe is
// empty: reset values, all-zero, all-ones, tight clamps and random settings.
// ----------------------------------------------------------------------------

module tb_pid_controller_step;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 80;
    localparam int DRAIN_CYCLES  = 8;
    localparam int STEPS_PER_SET = 130;
    localparam int NUM_SETS      = 8;

    typedef enum {SET_ZERO, SET_MAX, SET_RANDOM} t_settings_kind;

    typedef struct {
        logic               cmd;
        logic signed [15:0] sp;
        logic signed [15:0] mv;
        int unsigned        idle_before;
    } t_step_req;

    // DUT signals; the inputs are known from time zero
    logic                           i_clk         = 1'b0;
    logic                           i_rst_n       = 1'b0;
    logic                           i_valid       = 1'b0;
    logic                           o_stall;
    logic                           i_cmd         = 1'b0;
    logic signed [15:0]             i_set_point   = '0;
    logic signed [15:0]             i_measurement = '0;
    logic                           o_valid;
    logic                           i_stall       = 1'b0;
    logic signed [15:0]             o_drive;
    logic                           i_cfg_valid   = 1'b0;
    logic                           o_cfg_ready;
    logic [pidc_pkg::CFG_IDX_W-1:0] i_cfg_index   = '0;
    logic [29:0]                    i_cfg_data    = '0;

    // Controller settings and state as the bench sees them
    logic [14:0]          kp      = pidc_pkg::RST_PROP_GAIN;
    logic [14:0]          ki      = pidc_pkg::RST_INTEG_GAIN;
    logic [14:0]          kd      = pidc_pkg::RST_DERIV_GAIN;
    logic [14:0]          err_lim = pidc_pkg::RST_ERROR_BOUND;
    logic [29:0]          acc_lim = pidc_pkg::RST_INTEGRAL_BOUND;
    logic signed [31:0]   acc_error = '0;
    logic signed [15:0]   last_meas = '0;

    t_step_req            pending_steps[$];
    logic signed [15:0]   drive_expect[$];
    int                   steps_queued   = 0;
    int                   steps_accepted = 0;
    int                   check_errors   = 0;
    int                   quiet_cycles   = 0;
    logic                 step_taken     = 1'b0;
    int unsigned          idle_count     = 0;

    // Traffic shaping knobs
    bit                   gaps_on    = 1'b1;
    bit                   idling_on  = 1'b1;
    bit                   hold_req   = 1'b0;
    int unsigned          hold_count = 0;
    int unsigned          stall_left = 0;
    int unsigned          run_left   = 0;

    pid_controller_step u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_cmd         (i_cmd),
        .i_set_point   (i_set_point),
        .i_measurement (i_measurement),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_drive       (o_drive),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One compute step: updates the integrator and last measurement
    function automatic logic signed [15:0] next_drive(input logic signed [15:0] sp,
                                                      input logic signed [15:0] mv);
        logic signed [15:0] err;
        logic signed [15:0] p16;
        logic signed [15:0] d16;
        logic signed [31:0] i32;
        logic signed [31:0] s32;
        longint             e;
        longint             q;
        err = sp - mv;
        e   = err;
        if (e > longint'(err_lim))
            p16 = pidc_pkg::DRIVE_LIMIT;
        else if (e < -longint'(err_lim))
            p16 = -pidc_pkg::DRIVE_LIMIT;
        else
            p16 = 16'(longint'(kp) * e);

        // anti-windup: clamped integrator gives a fixed full-scale term
        q = longint'(acc_error) + e;
        if (q > longint'(acc_lim)) begin
            acc_error = 32'(longint'(acc_lim));
            i32       = pidc_pkg::INTEGRAL_LIMIT;
        end else if (q < -longint'(acc_lim)) begin
            acc_error = 32'(-longint'(acc_lim));
            i32       = -pidc_pkg::INTEGRAL_LIMIT;
        end else begin
            acc_error = 32'(q);
            i32       = 32'(longint'(ki) * longint'(acc_error));
        end

        d16       = 16'(longint'(kd) * (longint'(last_meas) - longint'(mv)));
        last_meas = mv;

        s32 = 32'(longint'(p16) + longint'(i32) + longint'(d16));
        q   = longint'(s32) / longint'(pidc_pkg::SCALE);
        if (q > longint'(pidc_pkg::DRIVE_LIMIT_W))
            q = pidc_pkg::DRIVE_LIMIT_W;
        else if (q < -longint'(pidc_pkg::DRIVE_LIMIT_W))
            q = -longint'(pidc_pkg::DRIVE_LIMIT_W);
        return 16'(q);
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(5, 30);
    endfunction

    function automatic t_step_req random_step();
        t_step_req          s;
        logic signed [15:0] corners [5];
        corners = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'shFFFF, 16'sh0001};
        s.cmd = ($urandom_range(0, 99) < 5);
        case ($urandom_range(0, 3))
            0: begin
                s.sp = 16'($urandom);
                s.mv = 16'($urandom);
            end
            1: begin
                // error inside the usual bound
                s.sp = 16'($urandom);
                s.mv = s.sp + 16'($urandom_range(0, 64)) - 16'sd32;
            end
            2: begin
                s.sp = corners[$urandom_range(0, 4)];
                s.mv = corners[$urandom_range(0, 4)];
            end
            default: begin
                s.sp = 16'($urandom_range(0, 400)) - 16'sd200;
                s.mv = 16'($urandom_range(0, 400)) - 16'sd200;
            end
        endcase
        s.idle_before = pick_gap();
        return s;
    endfunction

    task automatic push_step(input logic cmd, input logic signed [15:0] sp,
                             input logic signed [15:0] mv);
        pending_steps.push_back('{cmd, sp, mv, pick_gap()});
        steps_queued++;
    endtask

    task automatic write_reg(input logic [pidc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [29:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            pidc_pkg::CFG_PROP_GAIN:      kp      = val[14:0];
            pidc_pkg::CFG_INTEG_GAIN:     ki      = val[14:0];
            pidc_pkg::CFG_DERIV_GAIN:     kd      = val[14:0];
            pidc_pkg::CFG_ERROR_BOUND:    err_lim = val[14:0];
            pidc_pkg::CFG_INTEGRAL_BOUND: acc_lim = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic load_settings(input t_settings_kind kind);
        case (kind)
            SET_ZERO: begin
                for (int k = pidc_pkg::CFG_PROP_GAIN; k <= pidc_pkg::CFG_INTEGRAL_BOUND; k++)
                    write_reg(pidc_pkg::CFG_IDX_W'(k), '0);
            end
            SET_MAX: begin
                for (int k = pidc_pkg::CFG_PROP_GAIN; k <= pidc_pkg::CFG_INTEGRAL_BOUND; k++)
                    write_reg(pidc_pkg::CFG_IDX_W'(k), '1);
            end
            default: begin
                write_reg(pidc_pkg::CFG_PROP_GAIN, 30'($urandom));
                write_reg(pidc_pkg::CFG_INTEG_GAIN, 30'($urandom));
                write_reg(pidc_pkg::CFG_DERIV_GAIN, 30'($urandom));
                write_reg(pidc_pkg::CFG_ERROR_BOUND,
                          $urandom_range(0, 1) ? 30'($urandom_range(0, 600)) : 30'($urandom));
                write_reg(pidc_pkg::CFG_INTEGRAL_BOUND,
                          $urandom_range(0, 1) ? 30'($urandom_range(0, 20000)) : 30'($urandom));
            end
        endcase
    endtask

    // Let everything in flight come out, clears included
    task automatic drain();
        while (steps_accepted != steps_queued)
            @(posedge i_clk);
        while (drive_expect.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Request driver
    always @(negedge i_clk) begin : drv
        t_step_req nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || step_taken) begin
            if (pending_steps.size() == 0) begin
                i_valid <= 1'b0;
            end else if (idle_count < pending_steps[0].idle_before) begin
                i_valid <= 1'b0;
                idle_count++;
            end else begin
                nxt = pending_steps.pop_front();
                i_valid       <= 1'b1;
                i_cmd         <= nxt.cmd;
                i_set_point   <= nxt.sp;
                i_measurement <= nxt.mv;
                idle_count = 0;
            end
        end
    end

    // Result side back-pressure
    always @(negedge i_clk) begin : rx_stall
        int unsigned r;
        if (hold_req) begin
            i_stall <= 1'b1;
            if (hold_count == HOLD_CYCLES - 1) begin
                hold_count = 0;
                hold_req   = 1'b0;
            end else begin
                hold_count++;
            end
        end else if (!idling_on) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else if (run_left > 0) begin
            i_stall <= 1'b0;
            run_left--;
        end else begin
            i_stall <= 1'b0;
            r = $urandom_range(0, 99);
            run_left = $urandom_range(0, 12);
            if (r < 8)
                stall_left = $urandom_range(10, 40);
            else if (r < 50)
                stall_left = $urandom_range(1, 3);
            else
                stall_left = 0;
        end
    end

    // Monitor: predicts on request accept, checks on result accept
    always @(posedge i_clk) begin : mon
        logic signed [15:0] want;
        step_taken <= i_valid && !o_stall;
        if (i_rst_n) begin
            if (i_valid && !o_stall) begin
                steps_accepted++;
                if (i_cmd)
                    acc_error = '0;
                else
                    drive_expect.push_back(next_drive(i_set_point, i_measurement));
            end
            if (o_valid && !i_stall) begin
                if (drive_expect.size() == 0) begin
                    $error("drive: no result expected, actual %0d", o_drive);
                    check_errors++;
                end else begin
                    want = drive_expect.pop_front();
                    if (o_drive !== want) begin
                        $error("drive: expected %0d, actual %0d", want, o_drive);
                        check_errors++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: wrap of the error, P saturation at the bound, clear
        push_step(1'b0, 16'sd0, 16'sd0);
        push_step(1'b0, 16'sh7FFF, 16'sh8000);
        push_step(1'b0, 16'sh8000, 16'sh7FFF);
        push_step(1'b0, 16'sd254, 16'sd0);
        push_step(1'b0, 16'sd255, 16'sd0);
        push_step(1'b0, -16'sd255, 16'sd0);
        push_step(1'b0, -16'sd254, 16'sd0);
        push_step(1'b0, 16'sd200, 16'sd100);
        push_step(1'b1, 16'($urandom), 16'($urandom));
        push_step(1'b0, 16'sd5, 16'sd3);
        drain();

        // Full gains, tight clamps: integrator clamps both ways, D term wraps
        write_reg(pidc_pkg::CFG_PROP_GAIN, 30'h3FFF_FFFF);
        write_reg(pidc_pkg::CFG_INTEG_GAIN, 30'd32767);
        write_reg(pidc_pkg::CFG_DERIV_GAIN, 30'd32767);
        write_reg(pidc_pkg::CFG_ERROR_BOUND, 30'd0);
        write_reg(pidc_pkg::CFG_INTEGRAL_BOUND, 30'd100);
        // unused register slots must be ignored
        for (int k = pidc_pkg::CFG_INTEGRAL_BOUND + 1; k < (1 << pidc_pkg::CFG_IDX_W); k++)
            write_reg(pidc_pkg::CFG_IDX_W'(k), 30'($urandom));
        push_step(1'b0, 16'sd1000, 16'sd0);
        push_step(1'b0, -16'sd1000, 16'sd0);
        push_step(1'b0, 16'sd0, 16'sd0);
        push_step(1'b0, 16'sh7FFF, 16'sh8000);
        push_step(1'b0, 16'sh8000, 16'sh7FFF);
        push_step(1'b1, 16'($urandom), 16'($urandom));
        push_step(1'b0, 16'sd50, 16'sd0);
        push_step(1'b0, 16'sh8000, 16'sh8000);
        drain();

        for (int set_no = 0; set_no < NUM_SETS; set_no++) begin
            if (set_no == 0)
                load_settings(SET_ZERO);
            else if (set_no == 1)
                load_settings(SET_MAX);
            else
                load_settings(SET_RANDOM);
            // set 3 runs flat out; set 5 backs the pipe up behind a long hold-off
            idling_on = (set_no != 3);
            gaps_on   = (set_no != 3) && (set_no != 5);
            if (set_no == 5)
                hold_req = 1'b1;
            for (int n = 0; n < STEPS_PER_SET; n++) begin
                pending_steps.push_back(random_step());
                steps_queued++;
            end
            drain();
        end

        if (check_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
